/* sv/lss_pkg.sv */
// ----------------------------------------------------------------------------
// lss_pkg: shared definitions for the LIFO stack with search
// Request and result codes, field widths and the per-cell control struct.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 6;
  localparam int KIND_W    = 3;
  localparam int REQ_W     = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LIST   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PUSHED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POPPED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LISTED = 3'd4;
  localparam logic [KIND_W-1:0] KIND_MATCH  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DONE   = 3'd6;

  typedef struct packed {
    logic load;   // write the pushed word into this cell
    logic shift;  // take the word of the next cell up (rotate)
  } cell_ctrl_t;

endpackage

/* sv/lifo_stack_with_search.sv */
// ----------------------------------------------------------------------------
// lifo_stack_with_search: bounded LIFO stack of signed words with list/search
// A row of DEPTH cells holds the entries; a walk rotates the row past cell 0.
// ----------------------------------------------------------------------------
//
//  channel   ports                               handshake
//  -------   ---------------------------------   ------------------------------
//  request   req_type, value                     taken when start && !busy
//  result    kind, position, word, last          one cycle, marked by strobe
//
//  Push and pop results show in the cycle after the request is taken, and
//  a new item may be started in that very cycle.
//  List and search rotate the row of cells by one place per cycle, DEPTH
//  places in all, so every entry passes cell 0 and the row ends in its
//  original order, then the walk-done result follows.
//  Reset (synchronous) empties the stack; entry contents are left as they are.
//  The receiver cannot stall: each result is taken in the cycle it shows.
// ----------------------------------------------------------------------------
module lifo_stack_with_search #(
  parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [lss_pkg::REQ_W-1:0]          req_type,
  input  logic signed [lss_pkg::WORD_W-1:0]  value,
  output logic                               strobe,
  output logic [lss_pkg::KIND_W-1:0]         kind,
  output logic [lss_pkg::POS_W-1:0]          position,
  output logic signed [lss_pkg::WORD_W-1:0]  word,
  output logic                               last
);

  localparam int FW = $clog2(DEPTH + 1);             // fill count width
  localparam int CW = (DEPTH > 1) ? $clog2(DEPTH) : 1; // cell index width

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                            state;
  logic [FW-1:0]                     fill_count;
  logic [CW-1:0]                     walk_cnt;
  logic signed [lss_pkg::WORD_W-1:0] walk_key;
  logic                              walk_list;

  logic                              accept;
  logic                              full;
  logic                              in_range;
  logic [CW-1:0]                     top_idx;

  lss_pkg::cell_ctrl_t               ctrl [DEPTH];
  logic signed [lss_pkg::WORD_W-1:0] cell_q [DEPTH];

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign full     = (fill_count == FW'(DEPTH));
  // cell 0 holds entry walk_cnt after walk_cnt rotations
  assign in_range = (FW'(walk_cnt) < fill_count);
  assign top_idx  = CW'(fill_count - FW'(1));

  // Row of cells: cell i takes from cell i+1, the top cell wraps to cell 0.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctrl[i].load  = accept && (req_type == lss_pkg::REQ_PUSH) && !full
                           && (fill_count == FW'(i));
    assign ctrl[i].shift = (state == S_WALK);

    lss_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .load_data (value),
      .shift_in  (cell_q[(i == DEPTH - 1) ? 0 : i + 1]),
      .q         (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      walk_cnt   <= '0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (req_type)
              lss_pkg::REQ_PUSH: begin
                strobe   <= 1'b1;
                position <= '0;
                word     <= '0;
                last     <= 1'b1;
                if (full) begin
                  kind <= lss_pkg::KIND_FULL;
                end else begin
                  kind       <= lss_pkg::KIND_PUSHED;
                  fill_count <= fill_count + FW'(1);
                end
              end
              lss_pkg::REQ_POP: begin
                strobe   <= 1'b1;
                position <= '0;
                last     <= 1'b1;
                if (fill_count == '0) begin
                  kind <= lss_pkg::KIND_EMPTY;
                  word <= '0;
                end else begin
                  kind       <= lss_pkg::KIND_POPPED;
                  word       <= cell_q[top_idx];
                  fill_count <= fill_count - FW'(1);
                end
              end
              lss_pkg::REQ_LIST, lss_pkg::REQ_SEARCH: begin
                // hold the key and start the rotation
                state     <= S_WALK;
                walk_cnt  <= '0;
                walk_key  <= value;
                walk_list <= (req_type == lss_pkg::REQ_LIST);
              end
            endcase
          end
        end
        S_WALK: begin
          if (in_range && (walk_list || (cell_q[0] == walk_key))) begin
            strobe   <= 1'b1;
            kind     <= walk_list ? lss_pkg::KIND_LISTED : lss_pkg::KIND_MATCH;
            position <= lss_pkg::POS_W'(walk_cnt);
            word     <= walk_list ? cell_q[0] : '0;
            last     <= 1'b0;
          end
          // advance; after DEPTH rotations the row is back in order
          if (walk_cnt == CW'(DEPTH - 1)) begin
            state <= S_FINISH;
          end else begin
            walk_cnt <= walk_cnt + CW'(1);
          end
        end
        S_FINISH: begin
          strobe   <= 1'b1;
          kind     <= lss_pkg::KIND_DONE;
          position <= '0;
          word     <= '0;
          last     <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FW'(DEPTH))
    else $error("fill count above depth");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (kind == lss_pkg::KIND_DONE)) |-> last)
    else $error("walk done without last");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (accept && (req_type == lss_pkg::REQ_PUSH) && full)
      |=> (strobe && (kind == lss_pkg::KIND_FULL) && $stable(fill_count)))
    else $error("push on full stack not reported");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |=> (!busy && strobe && last))
    else $error("walk did not end cleanly");
`endif

endmodule

/* sv/lss_cell.sv */
// ----------------------------------------------------------------------------
// lss_cell: one stack entry
// Holds one word; loads a pushed word or takes its upper neighbour's word.
// ----------------------------------------------------------------------------
module lss_cell (
  input  logic                              clk,
  input  lss_pkg::cell_ctrl_t               ctrl,
  input  logic signed [lss_pkg::WORD_W-1:0] load_data,
  input  logic signed [lss_pkg::WORD_W-1:0] shift_in,
  output logic signed [lss_pkg::WORD_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= load_data;
    end else if (ctrl.shift) begin
      q <= shift_in;
    end
  end

endmodule
